// ===== rtl/core/pps_pkg.sv =====
package pps_pkg;

  // width of the per-tick planar step and of the arrival threshold
  localparam int unsigned STEP_W = 20;
  localparam int unsigned THR_W  = 20;
  // width of the climb gain, q0.16
  localparam int unsigned GAIN_W = 16;
  // width of the configuration register index
  localparam int unsigned IDX_W  = 3;

  localparam logic [STEP_W-1:0] STEP_RST = 20'd90;
  localparam logic [THR_W-1:0]  THR_RST  = 20'd84;
  localparam logic [GAIN_W-1:0] GAIN_RST = 16'd3277;

  // configuration register map
  typedef enum logic [IDX_W-1:0] {
    REG_START_LAT  = 3'd0,
    REG_START_LON  = 3'd1,
    REG_START_ALT  = 3'd2,
    REG_MOVE_STEP  = 3'd3,
    REG_ARRIVE_THR = 3'd4,
    REG_CLIMB_GAIN = 3'd5
  } reg_idx_e;

  // control pair for the serial arithmetic units
  typedef struct packed {
    logic load;
    logic step;
  } pps_ctrl_t;

endpackage

// ===== rtl/core/pps_smul.sv =====
module pps_smul #(
  parameter int unsigned AW = 32,
  parameter int unsigned BW = 32
) (
  input  logic                clk_i,
  input  pps_pkg::pps_ctrl_t  ctrl_i,
  input  logic [AW-1:0]       a_i,
  input  logic [BW-1:0]       b_i,
  output logic [AW+BW-1:0]    prod_o
);

  logic [AW+BW-1:0] prod_q, prod_d;
  logic [AW-1:0]    mcand_q, mcand_d;
  logic [AW:0]      part_sum;

  // shift-add, one multiplier bit per cycle while step is high, lsb first
  assign part_sum = {1'b0, prod_q[AW+BW-1:BW]} + (prod_q[0] ? {1'b0, mcand_q} : '0);

  always_comb begin
    prod_d  = prod_q;
    mcand_d = mcand_q;
    if (ctrl_i.load) begin
      prod_d  = {{AW{1'b0}}, b_i};
      mcand_d = a_i;
    end else if (ctrl_i.step) begin
      prod_d = {part_sum, prod_q[BW-1:1]};
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    mcand_q <= mcand_d;
  end

  assign prod_o = prod_q;

endmodule

// ===== rtl/core/pps_isqrt.sv =====
module pps_isqrt #(
  parameter int unsigned RW = 33
) (
  input  logic                clk_i,
  input  pps_pkg::pps_ctrl_t  ctrl_i,
  input  logic [2*RW-1:0]     op_i,
  output logic [RW-1:0]       root_o
);

  logic [2*RW-1:0] op_q, op_d;
  logic [RW+1:0]   rem_q, rem_d;
  logic [RW-1:0]   root_q, root_d;
  logic [RW+3:0]   rem_ext, trial, diff;
  logic            fits;

  // restoring root, two operand bits brought down per step
  assign rem_ext = {rem_q, op_q[2*RW-1 -: 2]};
  assign trial   = {2'b00, root_q, 2'b01};
  assign diff    = rem_ext - trial;
  assign fits    = rem_ext >= trial;

  always_comb begin
    op_d   = op_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (ctrl_i.load) begin
      op_d   = op_i;
      rem_d  = '0;
      root_d = '0;
    end else if (ctrl_i.step) begin
      op_d   = {op_q[2*RW-3:0], 2'b00};
      rem_d  = fits ? diff[RW+1:0] : rem_ext[RW+1:0];
      root_d = {root_q[RW-2:0], fits};
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign root_o = root_q;

endmodule

// ===== rtl/core/pps_sdiv.sv =====
module pps_sdiv #(
  parameter int unsigned AW = 32,
  parameter int unsigned LW = 33
) (
  input  logic                        clk_i,
  input  pps_pkg::pps_ctrl_t          ctrl_i,
  input  logic [AW-1:0]               a_i,
  input  logic [LW-1:0]               len_i,
  input  logic [pps_pkg::STEP_W-1:0]  s_i,
  output logic [pps_pkg::STEP_W-1:0]  q_o
);

  import pps_pkg::*;

  logic [AW-1:0]     a_q, a_d;
  logic [LW-1:0]     len_q, len_d;
  logic [STEP_W-1:0] s_q, s_d;
  logic [STEP_W-1:0] q_q, q_d;
  logic [LW:0]       r_q, r_d;
  logic              phase_q, phase_d;
  logic [LW:0]       r_sh, r_add, r_sel, r_red;
  logic              ge;

  // two half steps per step bit: double and reduce, then add and reduce
  assign r_sh  = {r_q[LW-1:0], 1'b0};
  assign r_add = r_q + {{(LW+1-AW){1'b0}}, a_q};
  assign r_sel = phase_q ? r_add : r_sh;
  assign ge    = r_sel >= {1'b0, len_q};
  assign r_red = ge ? (r_sel - {1'b0, len_q}) : r_sel;

  always_comb begin
    a_d     = a_q;
    len_d   = len_q;
    s_d     = s_q;
    q_d     = q_q;
    r_d     = r_q;
    phase_d = phase_q;
    if (ctrl_i.load) begin
      a_d     = a_i;
      len_d   = len_i;
      s_d     = s_i;
      q_d     = '0;
      r_d     = '0;
      phase_d = 1'b0;
    end else if (ctrl_i.step) begin
      if (!phase_q) begin
        q_d     = {q_q[STEP_W-2:0], ge};
        r_d     = r_red;
        phase_d = 1'b1;
      end else begin
        if (s_q[STEP_W-1]) begin
          q_d = q_q + STEP_W'(ge);
          r_d = r_red;
        end
        s_d     = {s_q[STEP_W-2:0], 1'b0};
        phase_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a_q     <= a_d;
    len_q   <= len_d;
    s_q     <= s_d;
    q_q     <= q_d;
    r_q     <= r_d;
    phase_q <= phase_d;
  end

  assign q_o = q_q;

endmodule

// ===== rtl/core/pursuit_position_step_top.sv =====
// channel  direction  handshake                 payload
// in       to block   in_valid_i / in_stall_o   func_i, target_latitude_i, target_longitude_i,
//                                               target_altitude_i
// out      from block out_valid_o / out_stall_i pursuer_latitude_o, pursuer_longitude_o,
//                                               pursuer_altitude_o, moved_o
// cfg      to block   cfg_we_i                  cfg_index_i, cfg_data_i
//
// an advance transaction runs from acceptance through load, squaring, root load, root, compare
// and, when the pursuer moves, the divider to completion, a reload goes straight to completion;
// squaring, root and scaled divider are bit-serial, the divider in two half steps per step bit
// one transaction in flight, the next is taken once its result sits in the output register
// a stalled output holds a finished transaction in completion and so stalls the input
// asynchronous active-low reset clears the pursuer to zero and the registers to their defaults
module pursuit_position_step_top #(
  parameter int unsigned POS_WIDTH = 32,
  parameter int unsigned ALT_WIDTH = 24,
  localparam int unsigned CFG_W0 = (POS_WIDTH > ALT_WIDTH) ? POS_WIDTH : ALT_WIDTH,
  localparam int unsigned CFG_WIDTH = (CFG_W0 > pps_pkg::STEP_W) ? CFG_W0 : pps_pkg::STEP_W
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         func_i,
  input  logic signed [POS_WIDTH-1:0]  target_latitude_i,
  input  logic signed [POS_WIDTH-1:0]  target_longitude_i,
  input  logic signed [ALT_WIDTH-1:0]  target_altitude_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [POS_WIDTH-1:0]  pursuer_latitude_o,
  output logic signed [POS_WIDTH-1:0]  pursuer_longitude_o,
  output logic signed [ALT_WIDTH-1:0]  pursuer_altitude_o,
  output logic                         moved_o,
  input  logic                         cfg_we_i,
  input  logic [pps_pkg::IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_WIDTH-1:0]         cfg_data_i
);

  import pps_pkg::*;

  // root width, the planar length can reach sqrt(2) * 2^POS_WIDTH
  localparam int unsigned RW        = POS_WIDTH + 1;
  localparam int unsigned DIV_STEPS = 2 * STEP_W;
  localparam int unsigned MAXN      = (DIV_STEPS > RW) ? DIV_STEPS : RW;
  localparam int unsigned CNT_W     = $clog2(MAXN);
  localparam int unsigned CMP_W     = ((RW > THR_W) ? RW : THR_W) + 1;
  // sum widths before saturation
  localparam int unsigned POS_DW    = ((POS_WIDTH > STEP_W) ? POS_WIDTH : STEP_W) + 2;
  localparam int unsigned ALT_DW    = ALT_WIDTH + 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SQ,
    ST_ROOTLD,
    ST_ROOT,
    ST_CMP,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e state_q;
  logic [CNT_W-1:0] cnt_q;

  // configuration
  logic [POS_WIDTH-1:0] start_lat_q, start_lon_q;
  logic [ALT_WIDTH-1:0] start_alt_q;
  logic [STEP_W-1:0]    step_q;
  logic [THR_W-1:0]     thr_q;
  logic [GAIN_W-1:0]    gain_q;

  // pursuer state
  logic [POS_WIDTH-1:0] cur_lat_q, cur_lon_q;
  logic [ALT_WIDTH-1:0] cur_alt_q;

  // per-transaction operands, offset magnitudes and signs
  logic [POS_WIDTH-1:0] mag_lat_q, mag_lon_q;
  logic [ALT_WIDTH-1:0] mag_alt_q;
  logic                 neg_lat_q, neg_lon_q, neg_alt_q;
  logic                 reload_q, moved_q;

  // output register
  logic                 out_valid_q;
  logic [POS_WIDTH-1:0] lat_out_q, lon_out_q;
  logic [ALT_WIDTH-1:0] alt_out_q;
  logic                 moved_out_q;

  // offsets against the current pursuer
  logic [POS_WIDTH:0]   dlat, dlon, alat, alon;
  logic [ALT_WIDTH:0]   dalt, aalt;

  // unit control and results
  pps_ctrl_t                sq_ctrl, alt_ctrl, root_ctrl, div_ctrl;
  logic [2*POS_WIDTH-1:0]   sq_lat, sq_lon;
  logic [2*POS_WIDTH:0]     sq_sum;
  logic [ALT_WIDTH+GAIN_W-1:0] alt_prod;
  logic [RW-1:0]            root;
  logic                     root_gt;
  logic [STEP_W-1:0]        q_lat, q_lon;

  // update path
  logic [POS_DW-1:0]    q_lat_ext, q_lon_ext, lat_sum, lon_sum;
  logic [ALT_DW-1:0]    da_ext, alt_sum;
  logic [POS_WIDTH-1:0] new_lat, new_lon;
  logic [ALT_WIDTH-1:0] new_alt;
  logic                 slot_free;

  function automatic logic [POS_WIDTH-1:0] sat_pos(input logic [POS_DW-1:0] s);
    logic [POS_DW-POS_WIDTH:0] hi_bits;
    logic [POS_WIDTH-1:0]      r;
    hi_bits = s[POS_DW-1:POS_WIDTH-1];
    if ((&hi_bits) || !(|hi_bits)) begin
      r = s[POS_WIDTH-1:0];
    end else if (s[POS_DW-1]) begin
      r = {1'b1, {(POS_WIDTH-1){1'b0}}};
    end else begin
      r = {1'b0, {(POS_WIDTH-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic logic [ALT_WIDTH-1:0] sat_alt(input logic [ALT_DW-1:0] s);
    logic [ALT_DW-ALT_WIDTH:0] hi_bits;
    logic [ALT_WIDTH-1:0]      r;
    hi_bits = s[ALT_DW-1:ALT_WIDTH-1];
    if ((&hi_bits) || !(|hi_bits)) begin
      r = s[ALT_WIDTH-1:0];
    end else if (s[ALT_DW-1]) begin
      r = {1'b1, {(ALT_WIDTH-1){1'b0}}};
    end else begin
      r = {1'b0, {(ALT_WIDTH-1){1'b1}}};
    end
    return r;
  endfunction

  // configuration writes, indices past the map are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_lat_q <= '0;
      start_lon_q <= '0;
      start_alt_q <= '0;
      step_q      <= STEP_RST;
      thr_q       <= THR_RST;
      gain_q      <= GAIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_START_LAT:  start_lat_q <= cfg_data_i[POS_WIDTH-1:0];
        REG_START_LON:  start_lon_q <= cfg_data_i[POS_WIDTH-1:0];
        REG_START_ALT:  start_alt_q <= cfg_data_i[ALT_WIDTH-1:0];
        REG_MOVE_STEP:  step_q      <= cfg_data_i[STEP_W-1:0];
        REG_ARRIVE_THR: thr_q       <= cfg_data_i[THR_W-1:0];
        REG_CLIMB_GAIN: gain_q      <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // offsets taken at acceptance, magnitudes always fit the field width
  assign dlat = {target_latitude_i[POS_WIDTH-1], target_latitude_i}
              - {cur_lat_q[POS_WIDTH-1], cur_lat_q};
  assign dlon = {target_longitude_i[POS_WIDTH-1], target_longitude_i}
              - {cur_lon_q[POS_WIDTH-1], cur_lon_q};
  assign dalt = {target_altitude_i[ALT_WIDTH-1], target_altitude_i}
              - {cur_alt_q[ALT_WIDTH-1], cur_alt_q};
  assign alat = dlat[POS_WIDTH] ? (~dlat + 1'b1) : dlat;
  assign alon = dlon[POS_WIDTH] ? (~dlon + 1'b1) : dlon;
  assign aalt = dalt[ALT_WIDTH] ? (~dalt + 1'b1) : dalt;

  // sequencing of the serial units
  assign sq_ctrl.load   = (state_q == ST_LOAD);
  assign sq_ctrl.step   = (state_q == ST_SQ);
  assign alt_ctrl.load  = (state_q == ST_LOAD);
  assign alt_ctrl.step  = (state_q == ST_SQ) && (cnt_q < CNT_W'(GAIN_W));
  assign root_ctrl.load = (state_q == ST_ROOTLD);
  assign root_ctrl.step = (state_q == ST_ROOT);
  assign div_ctrl.load  = (state_q == ST_CMP);
  assign div_ctrl.step  = (state_q == ST_DIV);

  // squared offsets, one bit per cycle
  pps_smul #(.AW(POS_WIDTH), .BW(POS_WIDTH)) u_sq_lat (
    .clk_i  (clk_i),
    .ctrl_i (sq_ctrl),
    .a_i    (mag_lat_q),
    .b_i    (mag_lat_q),
    .prod_o (sq_lat)
  );

  pps_smul #(.AW(POS_WIDTH), .BW(POS_WIDTH)) u_sq_lon (
    .clk_i  (clk_i),
    .ctrl_i (sq_ctrl),
    .a_i    (mag_lon_q),
    .b_i    (mag_lon_q),
    .prod_o (sq_lon)
  );

  // altitude gap times climb gain, runs alongside the squaring
  pps_smul #(.AW(ALT_WIDTH), .BW(GAIN_W)) u_climb (
    .clk_i  (clk_i),
    .ctrl_i (alt_ctrl),
    .a_i    (mag_alt_q),
    .b_i    (gain_q),
    .prod_o (alt_prod)
  );

  // planar length, operand padded to an even width
  assign sq_sum = {1'b0, sq_lat} + {1'b0, sq_lon};

  pps_isqrt #(.RW(RW)) u_root (
    .clk_i  (clk_i),
    .ctrl_i (root_ctrl),
    .op_i   ({1'b0, sq_sum}),
    .root_o (root)
  );

  assign root_gt = {{(CMP_W-RW){1'b0}}, root} > {{(CMP_W-THR_W){1'b0}}, thr_q};

  // step per axis, offset magnitude never exceeds the length
  pps_sdiv #(.AW(POS_WIDTH), .LW(RW)) u_div_lat (
    .clk_i  (clk_i),
    .ctrl_i (div_ctrl),
    .a_i    (mag_lat_q),
    .len_i  (root),
    .s_i    (step_q),
    .q_o    (q_lat)
  );

  pps_sdiv #(.AW(POS_WIDTH), .LW(RW)) u_div_lon (
    .clk_i  (clk_i),
    .ctrl_i (div_ctrl),
    .a_i    (mag_lon_q),
    .len_i  (root),
    .s_i    (step_q),
    .q_o    (q_lon)
  );

  // signed steps added to the pursuer, then saturated
  assign q_lat_ext = {{(POS_DW-STEP_W){1'b0}}, q_lat};
  assign q_lon_ext = {{(POS_DW-STEP_W){1'b0}}, q_lon};
  assign da_ext    = {2'b00, alt_prod[ALT_WIDTH+GAIN_W-1:GAIN_W]};

  assign lat_sum = {{(POS_DW-POS_WIDTH){cur_lat_q[POS_WIDTH-1]}}, cur_lat_q}
                 + (neg_lat_q ? (~q_lat_ext + 1'b1) : q_lat_ext);
  assign lon_sum = {{(POS_DW-POS_WIDTH){cur_lon_q[POS_WIDTH-1]}}, cur_lon_q}
                 + (neg_lon_q ? (~q_lon_ext + 1'b1) : q_lon_ext);
  assign alt_sum = {{2{cur_alt_q[ALT_WIDTH-1]}}, cur_alt_q}
                 + (neg_alt_q ? (~da_ext + 1'b1) : da_ext);

  always_comb begin
    if (reload_q) begin
      new_lat = start_lat_q;
      new_lon = start_lon_q;
      new_alt = start_alt_q;
    end else if (moved_q) begin
      new_lat = sat_pos(lat_sum);
      new_lon = sat_pos(lon_sum);
      new_alt = sat_alt(alt_sum);
    end else begin
      new_lat = cur_lat_q;
      new_lon = cur_lon_q;
      new_alt = cur_alt_q;
    end
  end

  // output register free, or emptied at this edge
  assign slot_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      cur_lat_q   <= '0;
      cur_lon_q   <= '0;
      cur_alt_q   <= '0;
      mag_lat_q   <= '0;
      mag_lon_q   <= '0;
      mag_alt_q   <= '0;
      neg_lat_q   <= 1'b0;
      neg_lon_q   <= 1'b0;
      neg_alt_q   <= 1'b0;
      reload_q    <= 1'b0;
      moved_q     <= 1'b0;
      out_valid_q <= 1'b0;
      lat_out_q   <= '0;
      lon_out_q   <= '0;
      alt_out_q   <= '0;
      moved_out_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            reload_q  <= func_i;
            moved_q   <= 1'b0;
            mag_lat_q <= alat[POS_WIDTH-1:0];
            mag_lon_q <= alon[POS_WIDTH-1:0];
            mag_alt_q <= aalt[ALT_WIDTH-1:0];
            neg_lat_q <= dlat[POS_WIDTH];
            neg_lon_q <= dlon[POS_WIDTH];
            neg_alt_q <= dalt[ALT_WIDTH];
            state_q   <= func_i ? ST_DONE : ST_LOAD;
          end
        end
        ST_LOAD: begin
          cnt_q   <= '0;
          state_q <= ST_SQ;
        end
        ST_SQ: begin
          if (cnt_q == CNT_W'(POS_WIDTH - 1)) begin
            cnt_q   <= '0;
            state_q <= ST_ROOTLD;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_ROOTLD: begin
          state_q <= ST_ROOT;
        end
        ST_ROOT: begin
          if (cnt_q == CNT_W'(RW - 1)) begin
            cnt_q   <= '0;
            state_q <= ST_CMP;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_CMP: begin
          // at or inside the threshold the pursuer holds still
          moved_q <= root_gt;
          state_q <= root_gt ? ST_DIV : ST_DONE;
        end
        ST_DIV: begin
          if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
            cnt_q   <= '0;
            state_q <= ST_DONE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_DONE: begin
          if (slot_free) begin
            cur_lat_q   <= new_lat;
            cur_lon_q   <= new_lon;
            cur_alt_q   <= new_alt;
            lat_out_q   <= new_lat;
            lon_out_q   <= new_lon;
            alt_out_q   <= new_alt;
            moved_out_q <= moved_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o          = (state_q != ST_IDLE);
  assign out_valid_o         = out_valid_q;
  assign pursuer_latitude_o  = lat_out_q;
  assign pursuer_longitude_o = lon_out_q;
  assign pursuer_altitude_o  = alt_out_q;
  assign moved_o             = moved_out_q;

  // an accepted transaction always leaves idle for the load or the result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_LOAD || state_q == ST_DONE))
    else $error("accepted transaction did not start");

  // the divider only runs on a length above the threshold, never zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> root_gt)
    else $error("division started at or below the arrival threshold");

  // a new result appears only out of the completion state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result raised outside completion");

endmodule

// ===== tb/tb_pursuit_position_step_top.sv =====
`timescale 1ns / 100ps

module tb_pursuit_position_step_top;

  import pps_pkg::*;

  // spare indices of the configuration port, no register behind them
  localparam logic [IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_B = 3'd7;

  // one pursuer position as it leaves the block
  typedef struct packed {
    logic signed [31:0] lat;
    logic signed [31:0] lon;
    logic signed [23:0] alt;
    logic               moved;
  } pursuer_t;

  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int          PHASES      = 8;
  localparam int          PHASE_ITEMS = 240;
  // wait after the final drain, longer than the longest advance transaction
  localparam int          SETTLE      = 150;

  logic                clk_i              = 1'b0;
  logic                rst_ni             = 1'b0;
  logic                in_valid_i         = 1'b0;
  logic                in_stall_o;
  logic                func_i             = 1'b0;
  logic signed [31:0]  target_latitude_i  = '0;
  logic signed [31:0]  target_longitude_i = '0;
  logic signed [23:0]  target_altitude_i  = '0;
  logic                out_valid_o;
  logic                out_stall_i        = 1'b0;
  logic signed [31:0]  pursuer_latitude_o;
  logic signed [31:0]  pursuer_longitude_o;
  logic signed [23:0]  pursuer_altitude_o;
  logic                moved_o;
  logic                cfg_we_i           = 1'b0;
  logic [pps_pkg::IDX_W-1:0] cfg_index_i  = REG_START_LAT;
  logic [31:0]         cfg_data_i         = '0;

  // predictor copy of the registers, reset values as in the block
  logic signed [31:0]          home_lat   = '0;
  logic signed [31:0]          home_lon   = '0;
  logic signed [23:0]          home_alt   = '0;
  logic [pps_pkg::STEP_W-1:0]  step_len   = pps_pkg::STEP_RST;
  logic [pps_pkg::THR_W-1:0]   arrive_thr = pps_pkg::THR_RST;
  logic [pps_pkg::GAIN_W-1:0]  climb_gain = pps_pkg::GAIN_RST;

  // predictor copy of the pursuer
  longint trk_lat = 0;
  longint trk_lon = 0;
  longint trk_alt = 0;

  pursuer_t pos_expect_q[$];
  int       pending      = 0;
  int       mismatch_cnt = 0;
  int       checked_cnt  = 0;
  int       sent_cnt     = 0;
  int       reload_cnt   = 0;
  int       moved_cnt    = 0;
  int       cycle_cnt    = 0;

  // idling control, no_idle shared by both sides, the hold-offs used by the receiver only
  bit       no_idle  = 1'b0;
  int       rx_wait  = 0;
  int       hold_len = 0;

  pursuit_position_step_top dut (.*);

  always #5 clk_i = ~clk_i;

  // hard stop in case the block hangs
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending);
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------------------

  // floor of the square root, bit by bit over the full 128-bit sum of squares
  function automatic logic [63:0] root_floor(input logic [127:0] v);
    logic [127:0] rem, res, bitv;
    rem  = v;
    res  = '0;
    bitv = 128'd1 << 126;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res[63:0];
  endfunction

  function automatic longint clamp(input longint v, input int w);
    longint top;
    top = (longint'(1) <<< (w - 1)) - 1;
    if (v > top) return top;
    if (v < -top - 1) return -top - 1;
    return v;
  endfunction

  // one tick of the pursuer, updates the tracked state and returns the position that leaves
  function automatic pursuer_t pursue_tick(input logic func, input logic signed [31:0] tgt_lat,
                                           input logic signed [31:0] tgt_lon,
                                           input logic signed [23:0] tgt_alt);
    pursuer_t     r;
    longint       dlat, dlon, gap, dalt, slat, slon;
    logic [127:0] mlat, mlon, span, qlat, qlon;
    logic [63:0]  mgap;
    r.moved = 1'b0;
    if (func) begin
      trk_lat = home_lat;
      trk_lon = home_lon;
      trk_alt = home_alt;
    end else begin
      dlat = tgt_lat - trk_lat;
      dlon = tgt_lon - trk_lon;
      mlat = (dlat < 0) ? -dlat : dlat;
      mlon = (dlon < 0) ? -dlon : dlon;
      span = root_floor(mlat * mlat + mlon * mlon);
      // at or inside the arrival radius nothing moves, which also keeps span off zero
      if (span > arrive_thr) begin
        gap  = tgt_alt - trk_alt;
        mgap = (gap < 0) ? -gap : gap;
        dalt = (mgap * climb_gain) >> 16;
        if (gap < 0) dalt = -dalt;
        // magnitudes are truncated before the sign goes back on
        qlat = mlat * step_len / span;
        qlon = mlon * step_len / span;
        slat = longint'(qlat[63:0]);
        slon = longint'(qlon[63:0]);
        if (dlat < 0) slat = -slat;
        if (dlon < 0) slon = -slon;
        trk_lat = clamp(trk_lat + slat, 32);
        trk_lon = clamp(trk_lon + slon, 32);
        trk_alt = clamp(trk_alt + dalt, 24);
        r.moved = 1'b1;
      end
    end
    r.lat = trk_lat[31:0];
    r.lon = trk_lon[31:0];
    r.alt = trk_alt[23:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------------------

  // register write, junk above the register width to show it is masked
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] data);
    case (idx)
      REG_START_ALT:                 data[31:24] = 8'($urandom);
      REG_MOVE_STEP, REG_ARRIVE_THR: data[31:20] = 12'($urandom);
      REG_CLIMB_GAIN:                data[31:16] = 16'($urandom);
      default: ;
    endcase
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_START_LAT:  home_lat   = data;
      REG_START_LON:  home_lon   = data;
      REG_START_ALT:  home_alt   = data[23:0];
      REG_MOVE_STEP:  step_len   = data[19:0];
      REG_ARRIVE_THR: arrive_thr = data[19:0];
      REG_CLIMB_GAIN: climb_gain = data[15:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // offer one transaction, valid stays high after acceptance so back-to-back transactions
  // never lower and raise it in the same step
  task automatic send_item(input logic func, input logic signed [31:0] tl,
                           input logic signed [31:0] tn, input logic signed [23:0] ta);
    int       gap;
    pursuer_t want;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    func_i             <= func;
    target_latitude_i  <= tl;
    target_longitude_i <= tn;
    target_altitude_i  <= ta;
    do @(posedge clk_i); while (in_stall_o);
    want = pursue_tick(func, tl, tn, ta);
    pos_expect_q.push_back(want);
    pending++;
    sent_cnt++;
    if (func) reload_cnt++;
  endtask

  // stop offering and wait until every outstanding position has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    wait (pending == 0);
    @(posedge clk_i);
  endtask

  // receiver: random stall before each result, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) rx_wait = no_idle ? 0 : $urandom_range(0, 10);
    if (hold_len > 0) begin
      hold_len--;
      out_stall_i <= 1'b1;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------------------
  // result checker
  // ---------------------------------------------------------------------------------------

  always @(posedge clk_i) begin : check_result
    pursuer_t want, got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.lat   = pursuer_latitude_o;
      got.lon   = pursuer_longitude_o;
      got.alt   = pursuer_altitude_o;
      got.moved = moved_o;
      if (moved_o) moved_cnt++;
      if (pending == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("%0t: unexpected result lat %h lon %h alt %h moved %b", $time,
                   got.lat, got.lon, got.alt, got.moved);
      end else begin
        want = pos_expect_q.pop_front();
        pending--;
        checked_cnt++;
        if (got !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("%0t: mismatch, expected lat %h lon %h alt %h moved %b,",
                     $time, want.lat, want.lon, want.alt, want.moved);
            $display("%0t:           got      lat %h lon %h alt %h moved %b",
                     $time, got.lat, got.lon, got.alt, got.moved);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------------------

  // start registers at both extremes, spare indices must leave them alone
  task automatic test_reload_extremes();
    write_reg(REG_START_LAT, 32'h7FFF_FFFF);
    write_reg(REG_START_LON, 32'h7FFF_FFFF);
    write_reg(REG_START_ALT, 32'h007F_FFFF);
    write_reg(REG_SPARE_A, $urandom);
    write_reg(REG_SPARE_B, $urandom);
    send_item(1'b1, $urandom, $urandom, 24'($urandom));
    drain();
    write_reg(REG_START_LAT, 32'h8000_0000);
    write_reg(REG_START_LON, 32'h8000_0000);
    write_reg(REG_START_ALT, 32'h0080_0000);
    send_item(1'b1, $urandom, $urandom, 24'($urandom));
    drain();
  endtask

  // longest offsets the fields allow, from corner to corner
  task automatic test_far_corner();
    write_reg(REG_MOVE_STEP, 32'h000F_FFFF);
    write_reg(REG_CLIMB_GAIN, 32'h0000_FFFF);
    send_item(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'h7F_FFFF);
    send_item(1'b0, 32'h8000_0000, 32'h8000_0000, 24'h80_0000);
    send_item(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 24'h7F_FFFF);
    drain();
  endtask

  // target on the pursuer gives zero length, one lsb away moves with a full overshoot
  task automatic test_zero_length();
    write_reg(REG_ARRIVE_THR, 32'h0);
    send_item(1'b0, trk_lat[31:0], trk_lon[31:0], 24'($urandom));
    send_item(1'b0, trk_lat[31:0] + 32'sd1, trk_lon[31:0], 24'($urandom));
    drain();
  endtask

  // offset length exactly on the threshold stays, one past it moves
  task automatic test_arrival_edge();
    write_reg(REG_START_LAT, 32'h0);
    write_reg(REG_START_LON, 32'h0);
    write_reg(REG_START_ALT, 32'h0);
    write_reg(REG_ARRIVE_THR, 32'd1000);
    write_reg(REG_MOVE_STEP, 32'(pps_pkg::STEP_RST));
    write_reg(REG_CLIMB_GAIN, 32'(pps_pkg::GAIN_RST));
    send_item(1'b1, $urandom, $urandom, 24'($urandom));
    send_item(1'b0, trk_lat[31:0] + 32'sd1000, trk_lon[31:0], 24'sd4000);
    send_item(1'b0, trk_lat[31:0] + 32'sd1001, trk_lon[31:0], 24'sd4000);
    send_item(1'b0, trk_lat[31:0], trk_lon[31:0] - 32'sd1000, -24'sd4000);
    send_item(1'b0, trk_lat[31:0] + 32'sd601, trk_lon[31:0] - 32'sd801, -24'sd4000);
    drain();
  endtask

  // step far beyond the offset drives both planar axes into saturation
  task automatic test_overshoot_saturation();
    write_reg(REG_START_LAT, 32'h7FFF_FF00);
    write_reg(REG_START_LON, 32'h8000_0100);
    write_reg(REG_START_ALT, 32'h007F_FF00);
    write_reg(REG_ARRIVE_THR, 32'h0);
    write_reg(REG_MOVE_STEP, 32'h000F_FFFF);
    write_reg(REG_CLIMB_GAIN, 32'h0000_FFFF);
    send_item(1'b1, $urandom, $urandom, 24'($urandom));
    send_item(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 24'h80_0000);
    send_item(1'b0, 32'h0, 32'h0, 24'h0);
    drain();
  endtask

  // zero step and zero gain still count as a move but change nothing
  task automatic test_zero_step_gain();
    write_reg(REG_MOVE_STEP, 32'h0);
    write_reg(REG_CLIMB_GAIN, 32'h0);
    send_item(1'b0, $urandom, $urandom, 24'($urandom));
    drain();
    write_reg(REG_MOVE_STEP, 32'(pps_pkg::STEP_RST));
    send_item(1'b0, $urandom, $urandom, 24'($urandom));
    drain();
  endtask

  // receiver holds off for a long stretch while the sender keeps pushing, so the output
  // register fills, the next transaction completes behind it and the input stalls
  task automatic test_output_backpressure();
    hold_len = 400;
    no_idle  = 1'b1;
    repeat (10) send_item(1'b0, $urandom, $urandom, 24'($urandom));
    no_idle  = 1'b0;
    drain();
  endtask

  function automatic logic [19:0] pick_span();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return 20'd1;
      2:       return 20'($urandom_range(2, 4095));
      3:       return 20'($urandom);
      default: return '1;
    endcase
  endfunction

  // new setting per phase, 0 keeps the reset step, threshold and gain, 1 and 2 pin extremes
  task automatic set_phase(input int p);
    logic [31:0] s_lat, s_lon, s_alt;
    logic [19:0] stp, thr;
    logic [15:0] gn;
    s_lat = $urandom;
    s_lon = $urandom;
    s_alt = $urandom;
    stp   = pick_span();
    thr   = pick_span();
    gn    = $urandom;
    case (p)
      0: begin
        stp = pps_pkg::STEP_RST;
        thr = pps_pkg::THR_RST;
        gn  = pps_pkg::GAIN_RST;
      end
      1: begin
        s_lat = 32'h7FFF_FFFF;
        s_lon = 32'h7FFF_FFFF;
        s_alt = 32'h007F_FFFF;
        stp   = '1;
        thr   = '0;
        gn    = '1;
      end
      2: begin
        s_lat = 32'h8000_0000;
        s_lon = 32'h8000_0000;
        s_alt = 32'h0080_0000;
        thr   = '1;
        gn    = '0;
      end
      default: ;
    endcase
    write_reg(REG_START_LAT, s_lat);
    write_reg(REG_START_LON, s_lon);
    write_reg(REG_START_ALT, s_alt);
    write_reg(REG_MOVE_STEP, 32'(stp));
    write_reg(REG_ARRIVE_THR, 32'(thr));
    write_reg(REG_CLIMB_GAIN, 32'(gn));
  endtask

  // mostly pursuit around the current position: near the arrival radius, small and mid
  // offsets, with reloads and fully random targets mixed in
  task automatic test_random_pursuit();
    int                 kind, k;
    longint             off_lat, off_lon, rim;
    logic signed [31:0] tl, tn;
    logic signed [23:0] ta;
    for (int p = 0; p < PHASES; p++) begin
      set_phase(p);
      send_item(1'b1, $urandom, $urandom, 24'($urandom));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // stretches with no idling on either side
        if (i % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
        kind    = $urandom_range(0, 99);
        k       = $urandom_range(0, 24);
        off_lat = longint'($urandom_range(0, 32'd1 << k));
        off_lon = longint'($urandom_range(0, 32'd1 << k));
        if ($urandom_range(0, 1)) off_lat = -off_lat;
        if ($urandom_range(0, 1)) off_lon = -off_lon;
        if (kind >= 8 && kind < 30) begin
          // one axis only, length just below, on or just above the threshold
          rim = longint'(arrive_thr) + longint'($urandom_range(0, 2)) - 1;
          if ($urandom_range(0, 1)) rim = -rim;
          if ($urandom_range(0, 1)) begin
            off_lat = rim;
            off_lon = 0;
          end else begin
            off_lat = 0;
            off_lon = rim;
          end
        end
        tl = trk_lat + off_lat;
        tn = trk_lon + off_lon;
        if (kind >= 65) begin
          tl = $urandom;
          tn = $urandom;
        end
        if ($urandom_range(0, 1)) ta = 24'($urandom);
        else ta = trk_alt + longint'($urandom_range(0, 4095)) - 2048;
        send_item(kind < 8, tl, tn, ta);
      end
      no_idle = 1'b0;
      drain();
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------------------

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reload_extremes();
    test_far_corner();
    test_zero_length();
    test_arrival_edge();
    test_overshoot_saturation();
    test_zero_step_gain();
    test_output_backpressure();
    test_random_pursuit();

    drain();
    repeat (SETTLE) @(posedge clk_i);

    $display("covered %0d transactions (%0d reloads), %0d results with a move",
             sent_cnt, reload_cnt, moved_cnt);
    $display("over %0d random settings, checked %0d results, %0d mismatches, %0d outstanding",
             PHASES, checked_cnt, mismatch_cnt, pending);
    if (mismatch_cnt == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== pursuit_position_step_top.f =====
rtl/core/pps_pkg.sv
rtl/core/pps_smul.sv
rtl/core/pps_isqrt.sv
rtl/core/pps_sdiv.sv
rtl/core/pursuit_position_step_top.sv
tb/tb_pursuit_position_step_top.sv
